// ===== design/hsis_pkg.sv =====
`timescale 1ns / 1ps

package hsis_pkg;

    // Position counter width; marks are 32 bits, the same width as the counter
    localparam int POS_BITS = 32;
    localparam int MARK_BITS = 32;

    // Result queue geometry
    localparam int FIFO_AW = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // Byte codes the scanner reacts to
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [FIFO_AW-1:0] fifo_ptr_t;
    typedef logic [FIFO_AW:0] fifo_level_t;

    // One result item
    typedef struct packed {
        logic [MARK_BITS-1:0] mark_position;
        logic                 last_of_run;
    } mark_t;

    // Up to two results produced by one byte
    typedef struct packed {
        logic [1:0] count;
        mark_t      first;
        mark_t      second;
    } mark_pair_t;

    // Queue status toward the scanner
    typedef struct packed {
        logic        room_for_pair;
        fifo_level_t level;
    } fifo_status_t;

    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_NUL || b == CH_TAB || b == CH_LF || b == CH_FF ||
               b == CH_CR || b == CH_SPACE;
    endfunction

    function automatic logic opens_tag(input logic [7:0] b);
        return b == CH_BANG || b == CH_QUEST || b == CH_SLASH ||
               (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
               (b >= CH_LOWER_A && b <= CH_LOWER_Z);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return b == CH_EQUAL || b == CH_DQUOTE || b == CH_SQUOTE || b == CH_GREATER;
    endfunction

    function automatic logic [MARK_BITS-1:0] to_mark(input pos_t p);
        return MARK_BITS'(p);
    endfunction

endpackage

// ===== design/hsis_text_if.sv =====
`timescale 1ns / 1ps

interface hsis_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== design/hsis_mark_if.sv =====
`timescale 1ns / 1ps

interface hsis_mark_if;
    logic        valid;
    logic        ready;
    logic [31:0] mark_position;
    logic        last_of_run;

    modport source (output valid, output mark_position, output last_of_run, input ready);
    modport sink (input valid, input mark_position, input last_of_run, output ready);
endinterface

// ===== design/html_structural_index_scanner_top.sv =====
`timescale 1ns / 1ps
// Flow: a byte is registered on transfer; its marks go into the result queue
// when it has room for two, and mark_out shows the queue head, a pair's first
// mark before its second. Throughput: one byte per cycle while the four-entry
// queue has room for two marks; mark_out drains one mark per cycle while ready.
// Reset: rst_n clears the position counter, scan state and queue at once.

module html_structural_index_scanner_top (
    input logic         clk,
    input logic         rst_n,
    hsis_text_if.sink   text_in,
    hsis_mark_if.source mark_out
);
    import hsis_pkg::*;

    mark_pair_t   push;
    fifo_status_t status;

    hsis_scan_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .status  (status),
        .push    (push)
    );

    hsis_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .status   (status),
        .mark_out (mark_out)
    );

    // Queue never exceeds its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        status.level <= fifo_level_t'(FIFO_DEPTH))
        else $error("result queue overflow");

    // Marks are only pushed when room for a pair was reported
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> status.room_for_pair)
        else $error("push without room");

    // A pair carries its end flag on the second mark only
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.first.last_of_run && push.second.last_of_run)
        else $error("bad end flag on mark pair");

    // After a push, the output presents a valid mark next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |=> mark_out.valid)
        else $error("pushed mark not presented");

endmodule

// ===== design/hsis_scan_core.sv =====
`timescale 1ns / 1ps

module hsis_scan_core (
    input  logic                  clk,
    input  logic                  rst_n,
    hsis_text_if.sink             text_in,
    input  hsis_pkg::fifo_status_t status,
    output hsis_pkg::mark_pair_t  push
);
    import hsis_pkg::*;

    // Input register
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       eot_reg;

    // Scanner state
    pos_t counter_reg, counter_next;
    logic in_run_reg, in_run_next;
    pos_t run_start_reg, run_start_next;
    pos_t last_reg, last_next;
    logic any_reg, any_next;
    logic pending_reg, pending_next;

    logic fire;
    pos_t p;
    pos_t p_prev;
    pos_t run_prev;
    logic blank;
    logic less_hit;
    logic run_end;
    logic emit_before;
    logic eff_any;
    pos_t eff_last;
    logic above;
    logic punct_hit;
    logic less_set;

    assign fire = valid_reg && status.room_for_pair;
    assign text_in.ready = !valid_reg || fire;

    // Capture the next byte whenever the register frees up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (text_in.ready)
        begin
            valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.ready && text_in.valid)
        begin
            byte_reg <= text_in.text_byte;
            eot_reg <= text_in.end_of_text;
        end
    end

    // Classify the byte and pick the marks
    always_comb
    begin
        p = counter_reg;
        p_prev = pos_t'(counter_reg - 1'b1);
        run_prev = pos_t'(run_start_reg - 1'b1);
        blank = is_blank(byte_reg);
        less_hit = pending_reg && opens_tag(byte_reg);
        run_end = !blank && in_run_reg;
        emit_before = run_end && (run_start_reg != '0) &&
                      !(any_reg && last_reg == run_prev);
        // A resolved '<' counts as emitted before the current byte is judged
        eff_any = any_reg || less_hit;
        eff_last = less_hit ? p_prev : last_reg;
        above = !eff_any || (eff_last < p);
        punct_hit = !blank && !run_end && is_punct(byte_reg) && above;
        less_set = !blank && !run_end && byte_reg == CH_LESS && above;

        push.count = 2'd0;
        push.first.mark_position = to_mark(p);
        push.first.last_of_run = 1'b1;
        push.second.mark_position = to_mark(p);
        push.second.last_of_run = 1'b1;
        last_next = last_reg;

        if (less_hit)
        begin
            push.first.mark_position = to_mark(p_prev);
            last_next = p_prev;
            if (punct_hit)
            begin
                push.count = 2'd2;
                push.first.last_of_run = 1'b0;
                last_next = p;
            end
            else
            begin
                push.count = 2'd1;
            end
        end
        else if (run_end)
        begin
            last_next = p;
            if (emit_before)
            begin
                push.count = 2'd2;
                push.first.mark_position = to_mark(run_prev);
                push.first.last_of_run = 1'b0;
            end
            else
            begin
                push.count = 2'd1;
            end
        end
        else if (punct_hit)
        begin
            push.count = 2'd1;
            last_next = p;
        end

        if (!fire)
        begin
            push.count = 2'd0;
        end

        any_next = any_reg || (push.count != 2'd0);
        in_run_next = blank;
        run_start_next = (blank && !in_run_reg) ? p : run_start_reg;
        pending_next = less_set;
        counter_next = pos_t'(counter_reg + 1'b1);
    end

    // Advance the state; drop everything at end of document
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            in_run_reg <= 1'b0;
            run_start_reg <= '0;
            last_reg <= '0;
            any_reg <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (eot_reg)
            begin
                counter_reg <= '0;
                in_run_reg <= 1'b0;
                run_start_reg <= '0;
                last_reg <= '0;
                any_reg <= 1'b0;
                pending_reg <= 1'b0;
            end
            else
            begin
                counter_reg <= counter_next;
                in_run_reg <= in_run_next;
                run_start_reg <= run_start_next;
                last_reg <= last_next;
                any_reg <= any_next;
                pending_reg <= pending_next;
            end
        end
    end

endmodule

// ===== design/hsis_result_fifo.sv =====
`timescale 1ns / 1ps

module hsis_result_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hsis_pkg::mark_pair_t  push,
    output hsis_pkg::fifo_status_t status,
    hsis_mark_if.source           mark_out
);
    import hsis_pkg::*;

    mark_t       mem [FIFO_DEPTH];
    fifo_ptr_t   wr_ptr_reg;
    fifo_ptr_t   rd_ptr_reg;
    fifo_level_t level_reg, level_next;
    logic        pop;
    mark_t       head;

    assign head = mem[rd_ptr_reg];
    assign mark_out.valid = level_reg != '0;
    assign mark_out.mark_position = head.mark_position;
    assign mark_out.last_of_run = head.last_of_run;
    assign pop = mark_out.valid && mark_out.ready;

    assign status.level = level_reg;
    assign status.room_for_pair = level_reg <= fifo_level_t'(FIFO_DEPTH - 2);

    always_comb
    begin
        level_next = fifo_level_t'(level_reg + fifo_level_t'(push.count) -
                                   fifo_level_t'(pop));
    end

    // Write up to two entries per cycle
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[fifo_ptr_t'(wr_ptr_reg + 1'b1)] <= push.second;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= fifo_ptr_t'(wr_ptr_reg + fifo_ptr_t'(push.count));
            if (pop)
            begin
                rd_ptr_reg <= fifo_ptr_t'(rd_ptr_reg + 1'b1);
            end
            level_reg <= level_next;
        end
    end

endmodule
